// ===== rtl/i2cmra_pkg.sv =====
// Shared types and constants for the I2C master register access unit.
// No dependencies; imported by the top-level module.
`default_nettype none

package i2cmra_pkg;

    typedef logic [1:0] req_t;
    typedef logic [2:0] status_t;
    typedef logic [5:0] phase_t;
    typedef logic [3:0] bitcnt_t;

    // Request codes; the unused code behaves as a phase tick.
    localparam req_t REQ_TICK  = 2'd0;
    localparam req_t REQ_WRITE = 2'd1;
    localparam req_t REQ_READ  = 2'd2;

    // Completion status codes.
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_BUS_BUSY  = 3'd1;
    localparam status_t ST_BUS_ERROR = 3'd2;
    localparam status_t ST_NO_ACK    = 3'd3;
    localparam status_t ST_ZERO_CNT  = 3'd4;
    localparam status_t ST_REFUSED   = 3'd5;

    // Sequencer phases. Byte phases occupy four codes each: the low two
    // bits select drive-low, clock-high, ack-low and ack-high.
    localparam phase_t PH_IDLE       = 6'd0;
    localparam phase_t PH_START_PULL = 6'd1;
    localparam phase_t PH_RS_RELEASE = 6'd2;
    localparam phase_t PH_RS_PULL    = 6'd3;
    localparam phase_t PH_DEV        = 6'd4;
    localparam phase_t PH_REG        = 6'd8;
    localparam phase_t PH_DAT        = 6'd12;
    localparam phase_t PH_DEVR       = 6'd16;
    localparam phase_t PH_RX         = 6'd20;
    localparam phase_t PH_STOP_OK    = 6'd24;
    localparam phase_t PH_STOP_NAK   = 6'd28;

    localparam logic [1:0] SUB_LOW     = 2'd0;
    localparam logic [1:0] SUB_HIGH    = 2'd1;
    localparam logic [1:0] SUB_ACK_LOW = 2'd2;

    localparam bitcnt_t BYTE_BITS = 4'd8;

endpackage

`default_nettype wire

// ===== rtl/i2c_master_register_access_unit.sv =====
// Top level of the I2C master register access unit: input word register,
// bus phase sequencer and result register. Depends on i2cmra_pkg.
//
//   channel | handshake            | word contents
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | req_type, dev_addr, reg_addr, write_data,
//           |                      | read_count, sda_in
//   out     | out_valid / out_ready| scl_out, sda_out, rx_byte, rx_valid,
//           |                      | rx_last, done_res, status, busy_res
//
// Each word is one bus phase and yields exactly one result word.
// A word waits in the input register until the sequencer step writes the
// state and the result register; a stalled result register delays that step.
// One word per cycle is sustained while the result side does not stall.
// A stalled result register holds the input register; the input register
// still accepts a word whenever it is empty or moving on.
// Reset clears the sequencer to idle with both lines released.
`default_nettype none

module i2c_master_register_access_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire i2cmra_pkg::req_t  req_type,
    input  wire logic [7:0]        dev_addr,
    input  wire logic [7:0]        reg_addr,
    input  wire logic [7:0]        write_data,
    input  wire logic [7:0]        read_count,
    input  wire logic              sda_in,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   scl_out,
    output logic                   sda_out,
    output logic [7:0]             rx_byte,
    output logic                   rx_valid,
    output logic                   rx_last,
    output logic                   done_res,
    output i2cmra_pkg::status_t    status,
    output logic                   busy_res
);
    import i2cmra_pkg::*;

    // Input word register.
    logic       in_valid_reg;
    req_t       req_reg;
    logic [7:0] dev_in_reg;
    logic [7:0] regaddr_in_reg;
    logic [7:0] data_in_reg;
    logic [7:0] count_in_reg;
    logic       sda_in_reg;

    // Sequencer state.
    phase_t     phase_reg,    phase_next;
    bitcnt_t    bit_cnt_reg,  bit_cnt_next;
    logic [7:0] shift_reg,    shift_next;
    logic [7:0] left_reg,     left_next;
    logic [7:0] held_dev_reg, held_dev_next;
    logic [7:0] held_reg_reg, held_reg_next;
    logic [7:0] held_dat_reg, held_dat_next;
    logic       read_mode_reg, read_mode_next;
    logic       scl_reg,      scl_next;
    logic       sda_reg,      sda_next;

    // Result register.
    logic       out_valid_reg;
    logic [7:0] rx_byte_reg,  rx_byte_next;
    logic       rx_valid_reg, rx_valid_next;
    logic       rx_last_reg,  rx_last_next;
    logic       done_reg,     done_next;
    status_t    status_reg,   status_next;
    logic       busy_reg;

    logic       step;
    logic       request;
    logic       nack;
    phase_t     base;
    logic [1:0] sub;

    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    assign request = (req_reg == REQ_WRITE) || (req_reg == REQ_READ);
    assign nack    = (left_reg <= 8'd1);
    assign base    = {phase_reg[5:2], 2'b00};
    assign sub     = phase_reg[1:0];

    always_comb
    begin
        phase_next     = phase_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        left_next      = left_reg;
        held_dev_next  = held_dev_reg;
        held_reg_next  = held_reg_reg;
        held_dat_next  = held_dat_reg;
        read_mode_next = read_mode_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        rx_byte_next   = 8'd0;
        rx_valid_next  = 1'b0;
        rx_last_next   = 1'b0;
        done_next      = 1'b0;
        status_next    = ST_OK;

        if (phase_reg == PH_IDLE)
        begin
            if (request)
            begin
                if ((req_reg == REQ_READ) && (count_in_reg == 8'd0))
                begin
                    done_next   = 1'b1;
                    status_next = ST_ZERO_CNT;
                end
                else
                begin
                    held_dev_next  = dev_in_reg;
                    held_reg_next  = regaddr_in_reg;
                    held_dat_next  = data_in_reg;
                    read_mode_next = (req_reg == REQ_READ);
                    left_next      = (req_reg == REQ_READ) ? count_in_reg : 8'd0;
                    scl_next       = 1'b1;
                    sda_next       = 1'b1;
                    // SDA already low means another master holds the bus.
                    if (!sda_in_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_BUS_BUSY;
                    end
                    else
                    begin
                        phase_next = PH_START_PULL;
                    end
                end
            end
        end
        else if (request)
        begin
            done_next   = 1'b1;
            status_next = ST_REFUSED;
        end
        else
        begin
            unique case (phase_reg) inside
                PH_START_PULL:
                begin
                    scl_next = 1'b1;
                    if (sda_in_reg)
                    begin
                        sda_next    = 1'b1;
                        done_next   = 1'b1;
                        status_next = ST_BUS_ERROR;
                        phase_next  = PH_IDLE;
                    end
                    else
                    begin
                        sda_next     = 1'b0;
                        shift_next   = held_dev_reg;
                        bit_cnt_next = '0;
                        phase_next   = PH_DEV;
                    end
                end
                PH_RS_RELEASE:
                begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = PH_RS_PULL;
                end
                PH_RS_PULL:
                begin
                    scl_next     = 1'b1;
                    sda_next     = 1'b0;
                    shift_next   = held_dev_reg + 8'd1;
                    bit_cnt_next = '0;
                    phase_next   = PH_DEVR;
                end
                [PH_DEV:PH_DEVR + 6'd3]:
                begin
                    if (sub == SUB_LOW)
                    begin
                        scl_next   = 1'b0;
                        sda_next   = shift_reg[7];
                        phase_next = base + 6'd1;
                    end
                    else if (sub == SUB_HIGH)
                    begin
                        scl_next     = 1'b1;
                        sda_next     = shift_reg[7];
                        shift_next   = {shift_reg[6:0], 1'b0};
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                        phase_next   = (bit_cnt_next >= BYTE_BITS) ? base + 6'd2 : base;
                    end
                    else if (sub == SUB_ACK_LOW)
                    begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        phase_next = base + 6'd3;
                    end
                    else
                    begin
                        // Acknowledge clock high; only the device byte's
                        // acknowledge is checked.
                        scl_next = 1'b1;
                        sda_next = 1'b1;
                        if (base == PH_DEV)
                        begin
                            if (sda_in_reg)
                            begin
                                phase_next = PH_STOP_NAK;
                            end
                            else
                            begin
                                shift_next   = held_reg_reg;
                                bit_cnt_next = '0;
                                phase_next   = PH_REG;
                            end
                        end
                        else if (base == PH_REG)
                        begin
                            if (read_mode_reg)
                            begin
                                phase_next = PH_RS_RELEASE;
                            end
                            else
                            begin
                                shift_next   = held_dat_reg;
                                bit_cnt_next = '0;
                                phase_next   = PH_DAT;
                            end
                        end
                        else if (base == PH_DAT)
                        begin
                            phase_next = PH_STOP_OK;
                        end
                        else
                        begin
                            shift_next   = '0;
                            bit_cnt_next = '0;
                            phase_next   = PH_RX;
                        end
                    end
                end
                [PH_RX:PH_RX + 6'd3]:
                begin
                    if (sub == SUB_LOW)
                    begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        phase_next = PH_RX + 6'd1;
                    end
                    else if (sub == SUB_HIGH)
                    begin
                        scl_next     = 1'b1;
                        sda_next     = 1'b1;
                        shift_next   = {shift_reg[6:0], sda_in_reg};
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                        if (bit_cnt_next >= BYTE_BITS)
                        begin
                            rx_valid_next = 1'b1;
                            rx_byte_next  = shift_next;
                            rx_last_next  = nack;
                            phase_next    = PH_RX + 6'd2;
                        end
                        else
                        begin
                            phase_next = PH_RX;
                        end
                    end
                    else if (sub == SUB_ACK_LOW)
                    begin
                        scl_next   = 1'b0;
                        sda_next   = nack;
                        phase_next = PH_RX + 6'd3;
                    end
                    else
                    begin
                        scl_next  = 1'b1;
                        sda_next  = nack;
                        left_next = (left_reg == 8'd0) ? 8'd0 : left_reg - 8'd1;
                        if (left_next == 8'd0)
                        begin
                            phase_next = PH_STOP_OK;
                        end
                        else
                        begin
                            shift_next   = '0;
                            bit_cnt_next = '0;
                            phase_next   = PH_RX;
                        end
                    end
                end
                [PH_STOP_OK:PH_STOP_NAK + 6'd2]:
                begin
                    if (sub == SUB_LOW)
                    begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        phase_next = base + 6'd1;
                    end
                    else if (sub == SUB_HIGH)
                    begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b0;
                        phase_next = base + 6'd2;
                    end
                    else if (sub == SUB_ACK_LOW)
                    begin
                        // SDA rising with SCL high is the STOP condition.
                        scl_next    = 1'b1;
                        sda_next    = 1'b1;
                        done_next   = 1'b1;
                        status_next = (base == PH_STOP_NAK) ? ST_NO_ACK : ST_OK;
                        phase_next  = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            bit_cnt_reg   <= '0;
            shift_reg     <= '0;
            left_reg      <= '0;
            held_dev_reg  <= '0;
            held_reg_reg  <= '0;
            held_dat_reg  <= '0;
            read_mode_reg <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (step)
            begin
                phase_reg     <= phase_next;
                bit_cnt_reg   <= bit_cnt_next;
                shift_reg     <= shift_next;
                left_reg      <= left_next;
                held_dev_reg  <= held_dev_next;
                held_reg_reg  <= held_reg_next;
                held_dat_reg  <= held_dat_next;
                read_mode_reg <= read_mode_next;
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg        <= req_type;
            dev_in_reg     <= dev_addr;
            regaddr_in_reg <= reg_addr;
            data_in_reg    <= write_data;
            count_in_reg   <= read_count;
            sda_in_reg     <= sda_in;
        end
        if (step)
        begin
            rx_byte_reg  <= rx_byte_next;
            rx_valid_reg <= rx_valid_next;
            rx_last_reg  <= rx_last_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
            busy_reg     <= (phase_next != PH_IDLE);
        end
    end

    assign out_valid = out_valid_reg;
    assign scl_out   = scl_reg;
    assign sda_out   = sda_reg;
    assign rx_byte   = rx_byte_reg;
    assign rx_valid  = rx_valid_reg;
    assign rx_last   = rx_last_reg;
    assign done_res  = done_reg;
    assign status    = status_reg;
    assign busy_res  = busy_reg;

    a_busy_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (busy_reg == (phase_reg != PH_IDLE)))
        else $error("busy flag disagrees with sequencer phase");

    a_rx_only_at_byte_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rx_valid_reg) |-> (phase_reg == PH_RX + 6'd2))
        else $error("received byte reported outside the receive acknowledge phase");

    a_refused_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg && (status_reg == ST_REFUSED)) |-> busy_reg)
        else $error("request refused while the sequencer was idle");

    a_status_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !done_reg) |-> (status_reg == ST_OK))
        else $error("non-zero status without completion");

    a_bit_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bit_cnt_reg <= BYTE_BITS)
        else $error("bit counter ran past one byte");

endmodule

`default_nettype wire

// ===== bench/i2cmra_bus_checker.sv =====
// Scoreboard for the I2C master register access unit: predicts each result word
// from the accepted input words and compares field by field.
// Depends on i2cmra_pkg for the request, status and phase codes.
module i2cmra_bus_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  i2cmra_pkg::req_t    req_type,
    input  logic [7:0]          dev_addr,
    input  logic [7:0]          reg_addr,
    input  logic [7:0]          write_data,
    input  logic [7:0]          read_count,
    input  logic                sda_in,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic                scl_out,
    input  logic                sda_out,
    input  logic [7:0]          rx_byte,
    input  logic                rx_valid,
    input  logic                rx_last,
    input  logic                done_res,
    input  i2cmra_pkg::status_t status,
    input  logic                busy_res,
    output int                  errors,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import i2cmra_pkg::*;

    localparam logic [1:0] SUB_ACK_HIGH = 2'd3;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [7:0] rx;
        logic       rxv;
        logic       rxl;
        logic       done;
        status_t    st;
        logic       busy;
    } bus_word_t;

    phase_t     phase;
    bitcnt_t    nbits;
    logic [7:0] shreg;
    logic [7:0] remaining;
    logic [7:0] dev_q;
    logic [7:0] regaddr_q;
    logic [7:0] data_q;
    logic       rd_mode;
    logic       scl_q;
    logic       sda_q;

    bus_word_t  predicted_bus[$];
    int         words_seen;

    initial
    begin
        errors = 0;
        pending = 0;
        words_seen = 0;
    end

    task automatic drive_lines(input logic scl, input logic sda);
        scl_q = scl;
        sda_q = sda;
    endtask

    task automatic load_shift(input logic [7:0] value, input phase_t next_phase);
        shreg = value;
        nbits = '0;
        phase = next_phase;
    endtask

    // One bus phase of the sequencer; updates the predicted state and
    // returns the result word that the phase produces.
    task automatic step_sequencer(input req_t req, input logic [7:0] dev, input logic [7:0] ra,
                                  input logic [7:0] wd, input logic [7:0] cnt,
                                  input logic sda, output bus_word_t w);
        phase_t     base;
        logic [1:0] sub;
        logic       last_byte;
        logic       is_req;

        w = '0;
        base = {phase[5:2], 2'b00};
        sub = phase[1:0];
        is_req = (req == REQ_WRITE) || (req == REQ_READ);

        if (phase == PH_IDLE)
        begin
            if (is_req)
            begin
                if (req == REQ_READ && cnt == 8'd0)
                begin
                    w.done = 1'b1;
                    w.st = ST_ZERO_CNT;
                end
                else
                begin
                    dev_q = dev;
                    regaddr_q = ra;
                    data_q = wd;
                    rd_mode = (req == REQ_READ);
                    remaining = rd_mode ? cnt : 8'd0;
                    drive_lines(1'b1, 1'b1);
                    if (!sda)
                    begin
                        w.done = 1'b1;
                        w.st = ST_BUS_BUSY;
                    end
                    else
                        phase = PH_START_PULL;
                end
            end
        end
        else if (is_req)
        begin
            // A request during a transaction is refused and the phase holds.
            w.done = 1'b1;
            w.st = ST_REFUSED;
        end
        else if (phase == PH_START_PULL)
        begin
            if (sda)
            begin
                drive_lines(1'b1, 1'b1);
                w.done = 1'b1;
                w.st = ST_BUS_ERROR;
                phase = PH_IDLE;
            end
            else
            begin
                drive_lines(1'b1, 1'b0);
                load_shift(dev_q, PH_DEV);
            end
        end
        else if (phase == PH_RS_RELEASE)
        begin
            drive_lines(1'b1, 1'b1);
            phase = PH_RS_PULL;
        end
        else if (phase == PH_RS_PULL)
        begin
            drive_lines(1'b1, 1'b0);
            load_shift(dev_q + 8'd1, PH_DEVR);
        end
        else if (phase >= PH_DEV && phase < PH_RX)
        begin
            if (sub == SUB_LOW)
            begin
                drive_lines(1'b0, shreg[7]);
                phase = {base[5:2], SUB_HIGH};
            end
            else if (sub == SUB_HIGH)
            begin
                drive_lines(1'b1, shreg[7]);
                shreg = {shreg[6:0], 1'b0};
                nbits = nbits + 4'd1;
                phase = (nbits >= BYTE_BITS) ? {base[5:2], SUB_ACK_LOW} : base;
            end
            else if (sub == SUB_ACK_LOW)
            begin
                drive_lines(1'b0, 1'b1);
                phase = {base[5:2], SUB_ACK_HIGH};
            end
            else
            begin
                drive_lines(1'b1, 1'b1);
                // Only the acknowledge of the first device byte matters.
                if (base == PH_DEV)
                begin
                    if (sda)
                        phase = PH_STOP_NAK;
                    else
                        load_shift(regaddr_q, PH_REG);
                end
                else if (base == PH_REG)
                begin
                    if (rd_mode)
                        phase = PH_RS_RELEASE;
                    else
                        load_shift(data_q, PH_DAT);
                end
                else if (base == PH_DAT)
                    phase = PH_STOP_OK;
                else
                    load_shift(8'd0, PH_RX);
            end
        end
        else if (phase >= PH_RX && phase < PH_STOP_OK)
        begin
            last_byte = (remaining <= 8'd1);
            if (sub == SUB_LOW)
            begin
                drive_lines(1'b0, 1'b1);
                phase = {base[5:2], SUB_HIGH};
            end
            else if (sub == SUB_HIGH)
            begin
                drive_lines(1'b1, 1'b1);
                shreg = {shreg[6:0], sda};
                nbits = nbits + 4'd1;
                if (nbits >= BYTE_BITS)
                begin
                    w.rxv = 1'b1;
                    w.rx = shreg;
                    w.rxl = last_byte;
                    phase = {base[5:2], SUB_ACK_LOW};
                end
                else
                    phase = base;
            end
            else if (sub == SUB_ACK_LOW)
            begin
                drive_lines(1'b0, last_byte);
                phase = {base[5:2], SUB_ACK_HIGH};
            end
            else
            begin
                drive_lines(1'b1, last_byte);
                if (remaining != 8'd0)
                    remaining = remaining - 8'd1;
                if (remaining == 8'd0)
                    phase = PH_STOP_OK;
                else
                    load_shift(8'd0, PH_RX);
            end
        end
        else if (phase >= PH_STOP_OK && phase < PH_STOP_NAK + 6'd3)
        begin
            if (sub == SUB_LOW)
            begin
                drive_lines(1'b0, 1'b0);
                phase = {base[5:2], SUB_HIGH};
            end
            else if (sub == SUB_HIGH)
            begin
                drive_lines(1'b1, 1'b0);
                phase = {base[5:2], SUB_ACK_LOW};
            end
            else if (sub == SUB_ACK_LOW)
            begin
                drive_lines(1'b1, 1'b1);
                w.done = 1'b1;
                w.st = (base == PH_STOP_NAK) ? ST_NO_ACK : ST_OK;
                phase = PH_IDLE;
            end
            else
                phase = PH_IDLE;
        end
        else
            phase = PH_IDLE;

        w.scl = scl_q;
        w.sda = sda_q;
        w.busy = (phase != PH_IDLE);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("word %0d %s: got %0h, expected %0h",
                                      words_seen, name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bus_word_t want;
        bus_word_t fresh;

        if (!rst_n)
        begin
            phase = PH_IDLE;
            nbits = '0;
            shreg = '0;
            remaining = '0;
            dev_q = '0;
            regaddr_q = '0;
            data_q = '0;
            rd_mode = 1'b0;
            scl_q = 1'b1;
            sda_q = 1'b1;
            predicted_bus.delete();
            pending <= 0;
        end
        else
        begin
            // The result word is registered after its input word is accepted, so a result word
            // never belongs to the input word accepted at the same edge.
            if (out_valid && out_ready)
            begin
                if (predicted_bus.size() == 0)
                    report_mismatch($sformatf("result word %0d arrived with none expected",
                                              words_seen));
                else
                begin
                    want = predicted_bus.pop_front();
                    check_field("scl_out", 8'(scl_out), 8'(want.scl));
                    check_field("sda_out", 8'(sda_out), 8'(want.sda));
                    check_field("rx_byte", rx_byte, want.rx);
                    check_field("rx_valid", 8'(rx_valid), 8'(want.rxv));
                    check_field("rx_last", 8'(rx_last), 8'(want.rxl));
                    check_field("done_res", 8'(done_res), 8'(want.done));
                    check_field("status", 8'(status), 8'(want.st));
                    check_field("busy_res", 8'(busy_res), 8'(want.busy));
                end
                words_seen++;
            end
            if (in_valid && in_ready)
            begin
                step_sequencer(req_type, dev_addr, reg_addr, write_data, read_count,
                               sda_in, fresh);
                predicted_bus.push_back(fresh);
            end
            pending <= predicted_bus.size();
        end
    end

endmodule

// ===== bench/i2c_master_register_access_unit_tb.sv =====
// Top of the testbench for the I2C master register access unit: clock, reset,
// bus transaction stimulus with random gaps and stalls, and the verdict.
// Depends on i2cmra_pkg, the unit itself and i2cmra_bus_checker.
module i2c_master_register_access_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cmra_pkg::*;

    localparam req_t REQ_SPARE    = 2'd3;
    localparam int   RANDOM_WORDS = 950;
    localparam int   CYCLE_LIMIT  = 400000;
    localparam int   SETTLE       = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    req_t       req_type = REQ_TICK;
    logic [7:0] dev_addr = '0;
    logic [7:0] reg_addr = '0;
    logic [7:0] write_data = '0;
    logic [7:0] read_count = '0;
    logic       sda_in = 1'b1;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       scl_out;
    logic       sda_out;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       rx_last;
    logic       done_res;
    status_t    status;
    logic       busy_res;

    int errors;
    int pending;
    int cycles = 0;
    int progress_words = 0;
    int writes_run = 0;
    int reads_run = 0;
    int bytes_read = 0;
    int refused_sent = 0;
    bit quiet = 1'b0;
    bit in_txn = 1'b0;

    i2c_master_register_access_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .dev_addr(dev_addr), .reg_addr(reg_addr),
        .write_data(write_data), .read_count(read_count), .sda_in(sda_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .scl_out(scl_out), .sda_out(sda_out), .rx_byte(rx_byte), .rx_valid(rx_valid),
        .rx_last(rx_last), .done_res(done_res), .status(status), .busy_res(busy_res)
    );

    i2cmra_bus_checker bus_check (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .dev_addr(dev_addr), .reg_addr(reg_addr),
        .write_data(write_data), .read_count(read_count), .sda_in(sda_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .scl_out(scl_out), .sda_out(sda_out), .rx_byte(rx_byte), .rx_valid(rx_valid),
        .rx_last(rx_last), .done_res(done_res), .status(status), .busy_res(busy_res),
        .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d words outstanding.", cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // The result side stalls with a chance of about three in ten, except in the quiet stretch.
    always @(posedge clk)
        out_ready <= quiet || ($urandom_range(99) >= 30);

    task automatic send_word(input req_t req, input logic [7:0] dev, input logic [7:0] ra,
                             input logic [7:0] wd, input logic [7:0] cnt,
                             input logic sda, input bit counted);
        if (!quiet && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        dev_addr <= dev;
        reg_addr <= ra;
        write_data <= wd;
        read_count <= cnt;
        sda_in <= sda;
        do
            @(posedge clk);
        while (!in_ready);
        if (counted)
            progress_words++;
    endtask

    // One bus phase word; inside a transaction a refused request is
    // occasionally slipped in ahead of it.
    task automatic tick(input logic sda);
        if (in_txn && $urandom_range(99) < 4)
        begin
            send_word(($urandom_range(1) == 0) ? REQ_WRITE : REQ_READ, 8'($urandom),
                      8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom_range(1)), 1'b0);
            refused_sent++;
        end
        send_word(($urandom_range(9) == 0) ? REQ_SPARE : REQ_TICK, 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), sda, in_txn);
    endtask

    task automatic tx_byte(input logic ack_sda);
        repeat (17) tick(1'($urandom_range(1)));
        tick(ack_sda);
    endtask

    task automatic rx_byte_in(input logic [7:0] value);
        int i;

        for (i = 7; i >= 0; i--)
        begin
            tick(1'($urandom_range(1)));
            tick(value[i]);
        end
        repeat (2) tick(1'($urandom_range(1)));
        bytes_read++;
    endtask

    task automatic stop_ticks();
        repeat (3) tick(1'($urandom_range(1)));
        in_txn = 1'b0;
    endtask

    // Request word plus the START pull; a low SDA at the request or a high
    // SDA during the pull ends the transaction early.
    task automatic start_txn(input req_t req, input logic [7:0] dev, input logic [7:0] ra,
                             input logic [7:0] wd, input logic [7:0] cnt,
                             input logic busy_fail, input logic err_fail, output logic started);
        started = 1'b0;
        send_word(req, dev, ra, wd, cnt, !busy_fail, 1'b1);
        if (busy_fail)
            return;
        in_txn = 1'b1;
        tick(err_fail);
        started = !err_fail;
        if (err_fail)
            in_txn = 1'b0;
    endtask

    task automatic do_write(input logic [7:0] dev, input logic [7:0] ra, input logic [7:0] wd,
                            input logic busy_fail, input logic err_fail, input logic nak);
        logic started;

        writes_run++;
        start_txn(REQ_WRITE, dev, ra, wd, 8'($urandom), busy_fail, err_fail, started);
        if (!started)
            return;
        tx_byte(nak);
        if (!nak)
        begin
            tx_byte(1'($urandom_range(1)));
            tx_byte(1'($urandom_range(1)));
        end
        stop_ticks();
    endtask

    task automatic do_read(input logic [7:0] dev, input logic [7:0] ra, input logic [7:0] cnt,
                           input logic busy_fail, input logic err_fail, input logic nak,
                           input bit rand_fill, input logic [7:0] fill);
        logic started;
        int   n;

        reads_run++;
        if (cnt == 8'd0)
        begin
            send_word(REQ_READ, dev, ra, 8'($urandom), cnt, 1'($urandom_range(1)), 1'b1);
            return;
        end
        start_txn(REQ_READ, dev, ra, 8'($urandom), cnt, busy_fail, err_fail, started);
        if (!started)
            return;
        tx_byte(nak);
        if (!nak)
        begin
            tx_byte(1'($urandom_range(1)));
            // repeated START: release, then pull
            repeat (2) tick(1'($urandom_range(1)));
            tx_byte(1'($urandom_range(1)));
            for (n = 0; n < cnt; n++)
                rx_byte_in(rand_fill ? 8'($urandom) : fill);
        end
        stop_ticks();
    endtask

    initial
    begin
        int         start_words;
        int         done_words;
        int         pick;
        logic [7:0] cnt;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle ticks, refusals, every ending of both transaction kinds.
        tick(1'b0);
        tick(1'b1);
        send_word(REQ_SPARE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
        do_read(8'hA0, 8'h10, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00);
        do_write(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        do_write(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0);
        do_write(8'h5A, 8'hA5, 8'h3C, 1'b1, 1'b0, 1'b0);
        do_write(8'h5A, 8'hA5, 8'h3C, 1'b0, 1'b1, 1'b0);
        do_write(8'h5A, 8'hA5, 8'h3C, 1'b0, 1'b0, 1'b1);
        do_read(8'hFF, 8'h00, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF);
        do_read(8'h00, 8'hFF, 8'd2, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
        do_read(8'h90, 8'h01, 8'd3, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00);
        do_read(8'h90, 8'h01, 8'd3, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00);
        do_read(8'h90, 8'h01, 8'd3, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
        do_read(8'h3C, 8'h80, 8'd255, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
        do_read(8'h3C, 8'h80, 8'd20, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00);

        // Random: mostly complete transactions with random contents.
        start_words = progress_words;
        done_words = 0;
        while (done_words < RANDOM_WORDS)
        begin
            quiet = (done_words > RANDOM_WORDS * 2 / 5) && (done_words < RANDOM_WORDS * 3 / 5);
            pick = $urandom_range(99);
            if (pick < 40)
                do_write(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(99) < 5,
                         $urandom_range(99) < 5, $urandom_range(99) < 10);
            else if (pick < 80)
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                    cnt = 8'($urandom_range(1, 3));
                else if (pick < 97)
                    cnt = 8'($urandom_range(4, 12));
                else
                    cnt = 8'($urandom_range(13, 40));
                do_read(8'($urandom), 8'($urandom), cnt, $urandom_range(99) < 5,
                        $urandom_range(99) < 5, $urandom_range(99) < 10, 1'b1, 8'h00);
            end
            else if (pick < 90)
                tick(1'($urandom_range(1)));
            else
                do_read(8'($urandom), 8'($urandom), 8'd0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00);
            done_words = progress_words - start_words;
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Ran %0d writes and %0d reads, clocking in %0d bytes, %0d refused requests.",
                 writes_run, reads_run, bytes_read, refused_sent);
        $display("Start failures, missing acknowledges, zero counts and idle ticks were mixed in.");
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
